// ===== hw/rtl/segmentation_softmax_accuracy_stats_assert.svh =====
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the segmentation statistics block.
// ---------------------------------------------------------------------------
`ifndef SEGMENTATION_SOFTMAX_ACCURACY_STATS_ASSERT_SVH
`define SEGMENTATION_SOFTMAX_ACCURACY_STATS_ASSERT_SVH

// The consequent must hold in the cycle after the antecedent.
`define SSAS_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("ssas: next-cycle check failed");

// The consequent must hold in the same cycle as the antecedent.
`define SSAS_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("ssas: same-cycle check failed");

`endif

// ===== hw/rtl/ssas_pkg.sv =====
// ---------------------------------------------------------------------------
// ssas_pkg
// Types, constants and tables for the segmentation statistics block.
// ---------------------------------------------------------------------------
package ssas_pkg;

    localparam int SCORE_W    = 16;
    localparam int INT_W      = 16;
    localparam int LABEL_W    = 4;
    localparam int MAP_W      = 64;
    localparam int CCOUNT_W   = 4;
    localparam int SUM_W      = 36;
    localparam int REC_CNT_W  = 20;
    localparam int MEAN_W     = 16;
    localparam int PROB_W     = 17;
    localparam int EXP_W      = 17;
    localparam int ESUM_W     = 20;
    localparam int T_W        = 18;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 64;
    localparam int NUM_SCORES = 8;

    localparam logic [14:0] LOG2E_Q14 = 15'd23637;
    localparam logic [3:0]  CCOUNT_RESET = 4'd8;

    localparam logic CMD_PIXEL  = 1'b0;
    localparam logic CMD_FINISH = 1'b1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_THRESHOLD   = 2'd0,
        CFG_CLASS_COUNT = 2'd1,
        CFG_LABEL_MAP   = 2'd2
    } cfg_reg_t;

    typedef struct packed {
        logic                      command;
        logic signed [INT_W-1:0]   pixel_intensity;
        logic [LABEL_W-1:0]        label_type;
        logic signed [SCORE_W-1:0] class_score_0;
        logic signed [SCORE_W-1:0] class_score_1;
        logic signed [SCORE_W-1:0] class_score_2;
        logic signed [SCORE_W-1:0] class_score_3;
        logic signed [SCORE_W-1:0] class_score_4;
        logic signed [SCORE_W-1:0] class_score_5;
        logic signed [SCORE_W-1:0] class_score_6;
        logic signed [SCORE_W-1:0] class_score_7;
    } in_item_t;

    typedef struct packed {
        logic                 is_overall;
        logic [2:0]           class_index;
        logic [REC_CNT_W-1:0] total_pixels;
        logic [REC_CNT_W-1:0] passed_pixels;
        logic [REC_CNT_W-1:0] truth_count;
        logic [REC_CNT_W-1:0] predicted_count;
        logic [REC_CNT_W-1:0] correct_count;
        logic [MEAN_W-1:0]    mean_probability;
        logic                 last;
    } out_item_t;

    typedef struct packed {
        logic load_item;
        logic arg_step;
        logic exp_start;
        logic exp_mul;
        logic exp_acc;
        logic pix_div_load;
        logic rec_div_load;
        logic commit;
        logic out_load;
        logic rec_next;
        logic clear_stats;
    } ctrl_cmd_t;

    typedef struct packed {
        logic in_finish;
        logic in_below;
        logic idx_last;
        logic rec_last;
        logic div_done;
    } dp_status_t;

    // 2^(-j/16) in Q1.16.
    function automatic logic [EXP_W-1:0] exp2_entry(input logic [4:0] j);
        logic [EXP_W-1:0] v;
        case (j)
            5'd0:    v = 17'd65536;
            5'd1:    v = 17'd62757;
            5'd2:    v = 17'd60097;
            5'd3:    v = 17'd57549;
            5'd4:    v = 17'd55109;
            5'd5:    v = 17'd52773;
            5'd6:    v = 17'd50535;
            5'd7:    v = 17'd48393;
            5'd8:    v = 17'd46341;
            5'd9:    v = 17'd44376;
            5'd10:   v = 17'd42495;
            5'd11:   v = 17'd40693;
            5'd12:   v = 17'd38968;
            5'd13:   v = 17'd37316;
            5'd14:   v = 17'd35734;
            5'd15:   v = 17'd34219;
            5'd16:   v = 17'd32768;
            default: v = 17'd0;
        endcase
        return v;
    endfunction

endpackage

// ===== hw/rtl/ssas_in_if.sv =====
// ---------------------------------------------------------------------------
// ssas_in_if
// Valid/ready channel carrying one pixel or finish transaction.
// ---------------------------------------------------------------------------
interface ssas_in_if
    import ssas_pkg::*;
;
    logic     valid;
    logic     ready;
    in_item_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== hw/rtl/ssas_out_if.sv =====
// ---------------------------------------------------------------------------
// ssas_out_if
// Valid/ready channel carrying one statistics record transaction.
// ---------------------------------------------------------------------------
interface ssas_out_if
    import ssas_pkg::*;
;
    logic      valid;
    logic      ready;
    out_item_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== hw/rtl/segmentation_softmax_accuracy_stats.sv =====
// ---------------------------------------------------------------------------
// segmentation_softmax_accuracy_stats
// Per-pixel argmax and softmax scoring with per-image accuracy records.
// ---------------------------------------------------------------------------
// Channel   Direction  Transaction
// in_ch     sink       one pixel, or a finish command
// out_ch    source     one overall or per-class statistics record
// cfg       write      threshold, class count, label map
//
// A pixel below threshold is counted and taken without scoring; a scored
// pixel runs argmax, a table exp per class, a division on the shared
// 36-step divider and a commit. A finish runs one division per record and
// holds each record until the output takes it.
// Reset clears all statistics at once; no item is taken while records wait.
// ---------------------------------------------------------------------------
module segmentation_softmax_accuracy_stats
    import ssas_pkg::*;
#(
    parameter int MAX_CLASSES = 8,
    parameter int COUNT_BITS  = 20
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    ssas_in_if.sink               in_ch,
    ssas_out_if.source            out_ch
);

    ctrl_cmd_t  cmd;
    dp_status_t st;

    ssas_controller u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_ch.valid),
        .in_ready  (in_ch.ready),
        .out_valid (out_ch.valid),
        .out_ready (out_ch.ready),
        .st        (st),
        .cmd       (cmd)
    );

    ssas_datapath #(
        .MAX_CLASSES (MAX_CLASSES),
        .COUNT_BITS  (COUNT_BITS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_item   (in_ch.data),
        .cmd       (cmd),
        .st        (st),
        .out_item  (out_ch.data)
    );

endmodule

// ===== hw/rtl/ssas_controller.sv =====
// ---------------------------------------------------------------------------
// ssas_controller
// Sequencer for pixel scoring and record emission.
// ---------------------------------------------------------------------------
`include "segmentation_softmax_accuracy_stats_assert.svh"

module ssas_controller
    import ssas_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    output logic       out_valid,
    input  logic       out_ready,
    input  dp_status_t st,
    output ctrl_cmd_t  cmd
);

    typedef enum logic [9:0] {
        S_IDLE  = 10'b0000000001,
        S_ARG   = 10'b0000000010,
        S_EXPM  = 10'b0000000100,
        S_EXPA  = 10'b0000001000,
        S_PLOAD = 10'b0000010000,
        S_PDIV  = 10'b0000100000,
        S_COMMT = 10'b0001000000,
        S_RLOAD = 10'b0010000000,
        S_RDIV  = 10'b0100000000,
        S_EMIT  = 10'b1000000000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        out_valid  = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load_item = 1'b1;
                    if (st.in_finish)
                    begin
                        state_next = S_RLOAD;
                    end
                    else if (!st.in_below)
                    begin
                        state_next = S_ARG;
                    end
                end
            end
            S_ARG:
            begin
                cmd.arg_step = 1'b1;
                if (st.idx_last)
                begin
                    cmd.exp_start = 1'b1;
                    state_next    = S_EXPM;
                end
            end
            S_EXPM:
            begin
                cmd.exp_mul = 1'b1;
                state_next  = S_EXPA;
            end
            S_EXPA:
            begin
                cmd.exp_acc = 1'b1;
                state_next  = st.idx_last ? S_PLOAD : S_EXPM;
            end
            S_PLOAD:
            begin
                cmd.pix_div_load = 1'b1;
                state_next       = S_PDIV;
            end
            S_PDIV:
            begin
                if (st.div_done)
                begin
                    state_next = S_COMMT;
                end
            end
            S_COMMT:
            begin
                cmd.commit = 1'b1;
                state_next = S_IDLE;
            end
            S_RLOAD:
            begin
                cmd.rec_div_load = 1'b1;
                state_next       = S_RDIV;
            end
            S_RDIV:
            begin
                if (st.div_done)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_EMIT;
                end
            end
            S_EMIT:
            begin
                out_valid = 1'b1;
                if (out_ready)
                begin
                    if (st.rec_last)
                    begin
                        cmd.clear_stats = 1'b1;
                        state_next      = S_IDLE;
                    end
                    else
                    begin
                        cmd.rec_next = 1'b1;
                        state_next   = S_RLOAD;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    `SSAS_ASSERT_NEXT(a_pdiv_to_commit, clk, rst_n, (state_reg == S_PDIV) && st.div_done, state_reg == S_COMMT)
    `SSAS_ASSERT_NEXT(a_emit_holds, clk, rst_n, (state_reg == S_EMIT) && !out_ready, out_valid)
    `SSAS_ASSERT_NEXT(a_last_ends_run, clk, rst_n, out_valid && out_ready && st.rec_last, in_ready)
    `SSAS_ASSERT_NOW(a_no_overlap, clk, rst_n, in_ready, !out_valid)

endmodule

// ===== hw/rtl/ssas_datapath.sv =====
// ---------------------------------------------------------------------------
// ssas_datapath
// Configuration, argmax, table exp, shared divider and statistics store.
// ---------------------------------------------------------------------------
module ssas_datapath
    import ssas_pkg::*;
#(
    parameter int MAX_CLASSES = 8,
    parameter int COUNT_BITS  = 20
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  in_item_t              in_item,
    input  ctrl_cmd_t             cmd,
    output dp_status_t            st,
    output out_item_t             out_item
);

    localparam int CW    = (MAX_CLASSES > 1) ? $clog2(MAX_CLASSES) : 1;
    localparam int IW    = $clog2(MAX_CLASSES + 1);
    localparam int DIV_W = (COUNT_BITS > ESUM_W) ? COUNT_BITS : ESUM_W;
    localparam int DCW   = $clog2(SUM_W + 1);
    localparam logic [CCOUNT_W-1:0] MAX_C = CCOUNT_W'(MAX_CLASSES);

    function automatic logic [REC_CNT_W-1:0] to_rec(input logic [COUNT_BITS-1:0] v);
        logic [63:0] w;
        w = 64'(v);
        return w[REC_CNT_W-1:0];
    endfunction

    function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] v);
        return (&v) ? v : v + COUNT_BITS'(1);
    endfunction

    function automatic logic [SUM_W-1:0] sat_add(input logic [SUM_W-1:0] s,
                                                 input logic [PROB_W-1:0] p);
        logic [SUM_W:0] r;
        r = {1'b0, s} + (SUM_W + 1)'(p);
        return r[SUM_W] ? {SUM_W{1'b1}} : r[SUM_W-1:0];
    endfunction

    // Configuration registers.
    logic signed [INT_W-1:0] thr_reg;
    logic [CCOUNT_W-1:0]     ccount_reg;
    logic [MAP_W-1:0]        map_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg    <= '0;
            ccount_reg <= CCOUNT_RESET;
            map_reg    <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_THRESHOLD:   thr_reg    <= cfg_data[INT_W-1:0];
                CFG_CLASS_COUNT: ccount_reg <= cfg_data[CCOUNT_W-1:0];
                CFG_LABEL_MAP:   map_reg    <= cfg_data;
                default:         thr_reg    <= thr_reg;
            endcase
        end
    end

    logic [IW-1:0] n_use;

    always_comb
    begin
        if (ccount_reg < CCOUNT_W'(2))
        begin
            n_use = IW'(2);
        end
        else if (ccount_reg > MAX_C)
        begin
            n_use = IW'(MAX_CLASSES);
        end
        else
        begin
            n_use = IW'(ccount_reg);
        end
    end

    // Item capture and truth mapping.
    logic signed [SCORE_W-1:0] all_sc [NUM_SCORES];
    logic [3:0]                map_entry;
    logic [CW-1:0]             truth_in;

    always_comb
    begin
        all_sc[0] = in_item.class_score_0;
        all_sc[1] = in_item.class_score_1;
        all_sc[2] = in_item.class_score_2;
        all_sc[3] = in_item.class_score_3;
        all_sc[4] = in_item.class_score_4;
        all_sc[5] = in_item.class_score_5;
        all_sc[6] = in_item.class_score_6;
        all_sc[7] = in_item.class_score_7;
        map_entry = map_reg[{in_item.label_type, 2'b00} +: 4];
        truth_in  = ({1'b0, map_entry} >= 5'(n_use)) ? '0 : map_entry[CW-1:0];
    end

    logic signed [SCORE_W-1:0] sc_reg [MAX_CLASSES];
    logic [CW-1:0]             truth_reg;
    logic [CW-1:0]             pred_reg;
    logic signed [SCORE_W-1:0] best_reg;
    logic [IW-1:0]             idx_reg;
    logic [T_W-1:0]            t_reg;
    logic [ESUM_W-1:0]         esum_reg;
    logic [EXP_W-1:0]          et_reg;

    logic [IW-1:0]             idx_m1;
    logic [CW-1:0]             idx_c;
    logic signed [SCORE_W-1:0] cur_sc;
    logic [SCORE_W:0]          score_gap;
    logic [31:0]               prod;

    assign idx_m1    = idx_reg - IW'(1);
    assign idx_c     = idx_reg[CW-1:0];
    assign cur_sc    = sc_reg[idx_c];
    assign score_gap = {best_reg[SCORE_W-1], best_reg} - {cur_sc[SCORE_W-1], cur_sc};
    assign prod      = 32'(score_gap) * 32'(LOG2E_Q14);

    // Table exp of the registered exponent.
    logic [9:0]       t_int;
    logic [3:0]       t_j;
    logic [3:0]       t_r;
    logic [EXP_W-1:0] tab_a;
    logic [EXP_W-1:0] tab_b;
    logic [EXP_W-1:0] tab_d;
    logic [EXP_W+3:0] tab_dr;
    logic [EXP_W-1:0] base;
    logic [EXP_W-1:0] e_val;

    always_comb
    begin
        t_int  = t_reg[T_W-1:8];
        t_j    = t_reg[7:4];
        t_r    = t_reg[3:0];
        tab_a  = exp2_entry({1'b0, t_j});
        tab_b  = exp2_entry(5'(t_j) + 5'd1);
        tab_d  = tab_a - tab_b;
        tab_dr = (EXP_W + 4)'(tab_d) * (EXP_W + 4)'(t_r);
        base   = tab_a - tab_dr[EXP_W+3:4];
        e_val  = (t_int >= 10'd17) ? '0 : base >> t_int[4:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg <= '0;
        end
        else if (cmd.load_item)
        begin
            idx_reg <= (in_item.command == CMD_FINISH) ? IW'(0) : IW'(1);
        end
        else if (cmd.exp_start)
        begin
            idx_reg <= '0;
        end
        else if (cmd.arg_step || cmd.exp_acc || cmd.rec_next)
        begin
            idx_reg <= idx_reg + IW'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            for (int c = 0; c < MAX_CLASSES; c++)
            begin
                sc_reg[c] <= all_sc[c];
            end
            truth_reg <= truth_in;
            best_reg  <= in_item.class_score_0;
            pred_reg  <= '0;
        end
        else if (cmd.arg_step && (cur_sc > best_reg))
        begin
            best_reg <= cur_sc;
            pred_reg <= idx_c;
        end
        if (cmd.exp_mul)
        begin
            t_reg <= prod[31:14];
        end
        if (cmd.exp_start)
        begin
            esum_reg <= '0;
            et_reg   <= '0;
        end
        else if (cmd.exp_acc)
        begin
            esum_reg <= esum_reg + ESUM_W'(e_val);
            if (idx_c == truth_reg)
            begin
                et_reg <= e_val;
            end
        end
    end

    // Statistics store.
    logic [COUNT_BITS-1:0] total_reg;
    logic [COUNT_BITS-1:0] passed_reg;
    logic [COUNT_BITS-1:0] ocorrect_reg;
    logic [SUM_W-1:0]      osum_reg;
    logic [COUNT_BITS-1:0] ctruth_reg   [MAX_CLASSES];
    logic [COUNT_BITS-1:0] cpred_reg    [MAX_CLASSES];
    logic [COUNT_BITS-1:0] ccorrect_reg [MAX_CLASSES];
    logic [SUM_W-1:0]      csum_reg     [MAX_CLASSES];

    logic [SUM_W-1:0] dq_reg;
    logic [PROB_W-1:0] prob;
    logic              hit;

    assign prob = dq_reg[PROB_W-1:0];
    assign hit  = (pred_reg == truth_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            total_reg    <= '0;
            passed_reg   <= '0;
            ocorrect_reg <= '0;
            osum_reg     <= '0;
            for (int c = 0; c < MAX_CLASSES; c++)
            begin
                ctruth_reg[c]   <= '0;
                cpred_reg[c]    <= '0;
                ccorrect_reg[c] <= '0;
                csum_reg[c]     <= '0;
            end
        end
        else if (cmd.clear_stats)
        begin
            total_reg    <= '0;
            passed_reg   <= '0;
            ocorrect_reg <= '0;
            osum_reg     <= '0;
            for (int c = 0; c < MAX_CLASSES; c++)
            begin
                ctruth_reg[c]   <= '0;
                cpred_reg[c]    <= '0;
                ccorrect_reg[c] <= '0;
                csum_reg[c]     <= '0;
            end
        end
        else if (cmd.load_item && (in_item.command == CMD_PIXEL))
        begin
            total_reg <= sat_inc(total_reg);
        end
        else if (cmd.commit)
        begin
            passed_reg <= sat_inc(passed_reg);
            osum_reg   <= sat_add(osum_reg, prob);
            if (hit)
            begin
                ocorrect_reg <= sat_inc(ocorrect_reg);
            end
            for (int c = 0; c < MAX_CLASSES; c++)
            begin
                if (CW'(c) == truth_reg)
                begin
                    ctruth_reg[c] <= sat_inc(ctruth_reg[c]);
                    csum_reg[c]   <= sat_add(csum_reg[c], prob);
                    if (hit)
                    begin
                        ccorrect_reg[c] <= sat_inc(ccorrect_reg[c]);
                    end
                end
                if (CW'(c) == pred_reg)
                begin
                    cpred_reg[c] <= sat_inc(cpred_reg[c]);
                end
            end
        end
    end

    // Record selection.
    logic [CW-1:0]         rec_c;
    logic                  rec_ovr;
    logic [COUNT_BITS-1:0] rec_cnt;
    logic [SUM_W-1:0]      rec_sum;

    assign rec_c   = idx_m1[CW-1:0];
    assign rec_ovr = (idx_reg == '0);
    assign rec_cnt = rec_ovr ? passed_reg : ctruth_reg[rec_c];
    assign rec_sum = rec_ovr ? osum_reg : csum_reg[rec_c];

    // Restoring divider, one quotient bit per cycle.
    logic [DIV_W-1:0] rem_reg;
    logic [DIV_W-1:0] den_reg;
    logic [DCW-1:0]   dcnt_reg;
    logic [DIV_W:0]   rem_sh;
    logic             q_bit;

    assign rem_sh = {rem_reg, dq_reg[SUM_W-1]};
    assign q_bit  = (rem_sh >= {1'b0, den_reg});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dcnt_reg <= '0;
        end
        else if (cmd.pix_div_load || cmd.rec_div_load)
        begin
            dcnt_reg <= DCW'(SUM_W);
        end
        else if (dcnt_reg != '0)
        begin
            dcnt_reg <= dcnt_reg - DCW'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.pix_div_load)
        begin
            rem_reg <= '0;
            den_reg <= DIV_W'(esum_reg);
            dq_reg  <= SUM_W'({et_reg, 16'h0000});
        end
        else if (cmd.rec_div_load)
        begin
            rem_reg <= '0;
            den_reg <= DIV_W'(rec_cnt);
            dq_reg  <= rec_sum;
        end
        else if (dcnt_reg != '0)
        begin
            rem_reg <= q_bit ? DIV_W'(rem_sh - {1'b0, den_reg}) : rem_sh[DIV_W-1:0];
            dq_reg  <= {dq_reg[SUM_W-2:0], q_bit};
        end
    end

    // Output record register.
    logic [MEAN_W-1:0] mean;

    always_comb
    begin
        if (rec_cnt == '0)
        begin
            mean = '0;
        end
        else if (|dq_reg[SUM_W-1:MEAN_W])
        begin
            mean = {MEAN_W{1'b1}};
        end
        else
        begin
            mean = dq_reg[MEAN_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            out_item.is_overall       <= rec_ovr;
            out_item.class_index      <= rec_ovr ? 3'd0 : 3'(rec_c);
            out_item.total_pixels     <= rec_ovr ? to_rec(total_reg) : '0;
            out_item.passed_pixels    <= rec_ovr ? to_rec(passed_reg) : '0;
            out_item.truth_count      <= to_rec(rec_cnt);
            out_item.predicted_count  <= rec_ovr ? to_rec(passed_reg)
                                                 : to_rec(cpred_reg[rec_c]);
            out_item.correct_count    <= rec_ovr ? to_rec(ocorrect_reg)
                                                 : to_rec(ccorrect_reg[rec_c]);
            out_item.mean_probability <= mean;
            out_item.last             <= (idx_reg == n_use);
        end
    end

    assign st.in_finish = (in_item.command == CMD_FINISH);
    assign st.in_below  = (in_item.pixel_intensity < thr_reg);
    assign st.idx_last  = (idx_reg == (n_use - IW'(1)));
    assign st.rec_last  = (idx_reg == n_use);
    assign st.div_done  = (dcnt_reg == '0);

endmodule

// ===== verif/tb.sv =====
// ----------------------------------------------------------------------------
// Segmentation softmax accuracy statistics testbench
// Streams pixel and finish transactions through the block under several
// threshold, class-count and label-map settings, predicts every statistics
// record and compares the records field by field as they leave the block.
// ----------------------------------------------------------------------------
module tb
    import ssas_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NCLS = 8;
    localparam longint CNT_SAT = (64'd1 << 20) - 1;
    localparam longint SUM_SAT = (64'd1 << 36) - 1;
    localparam int IDLE_LIMIT = 3000;
    localparam int SETTLE_CYCLES = 400;

    typedef struct {
        in_item_t  item;
        bit        typed;
        out_item_t first_record;
    } stim_row_t;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    ssas_in_if  in_ch ();
    ssas_out_if out_ch ();

    segmentation_softmax_accuracy_stats dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_ch     (in_ch.sink),
        .out_ch    (out_ch.source)
    );

    logic signed [15:0] threshold;
    logic [3:0]         class_cfg;
    logic [63:0]        label_map;

    longint total_cnt;
    longint passed_cnt;
    longint correct_cnt;
    longint prob_total;
    longint truth_cnt [NCLS];
    longint pred_cnt [NCLS];
    longint hit_cnt [NCLS];
    longint prob_sum [NCLS];

    out_item_t expected_records[$];
    int        errors;
    int        idle_cycles = 0;
    bit        no_idle;

    longint exp2_q16 [17] = '{65536, 62757, 60097, 57549, 55109, 52773, 50535, 48393,
                              46341, 44376, 42495, 40693, 38968, 37316, 35734, 34219,
                              32768};

    initial clk = 1'b0;
    always #10 clk = ~clk;

    function automatic longint sat_inc(longint c);
        return (c >= CNT_SAT) ? CNT_SAT : c + 1;
    endfunction

    function automatic longint mean_prob(longint s, longint c);
        longint q;
        if (c == 0)
            return 0;
        q = s / c;
        return (q > 65535) ? 65535 : q;
    endfunction

    function automatic longint exp_weight(longint d);
        longint t;
        longint k;
        int     j;
        longint r;
        longint base;
        t = (d * 23637) >>> 14;
        k = t >>> 8;
        j = int'((t >>> 4) & 15);
        r = t & 15;
        if (k >= 17)
            return 0;
        base = exp2_q16[j] - (((exp2_q16[j] - exp2_q16[j + 1]) * r) >>> 4);
        return base >>> k;
    endfunction

    function automatic void clear_accumulators();
        total_cnt = 0;
        passed_cnt = 0;
        correct_cnt = 0;
        prob_total = 0;
        for (int c = 0; c < NCLS; c++)
        begin
            truth_cnt[c] = 0;
            pred_cnt[c] = 0;
            hit_cnt[c] = 0;
            prob_sum[c] = 0;
        end
    endfunction

    // Updates the statistics for one transaction and returns the number of
    // records that it releases.
    function automatic int accumulate_pixel(in_item_t it);
        int          n;
        int          truth;
        int          pred;
        longint      sc [NCLS];
        longint      wsum;
        longint      wtruth;
        longint      w;
        longint      p;
        out_item_t   rec;
        n = (class_cfg < 2) ? 2 : ((class_cfg > NCLS) ? NCLS : int'(class_cfg));
        if (it.command == CMD_FINISH)
        begin
            rec = '0;
            rec.is_overall = 1'b1;
            rec.total_pixels = total_cnt[19:0];
            rec.passed_pixels = passed_cnt[19:0];
            rec.truth_count = passed_cnt[19:0];
            rec.predicted_count = passed_cnt[19:0];
            rec.correct_count = correct_cnt[19:0];
            rec.mean_probability = 16'(mean_prob(prob_total, passed_cnt));
            expected_records.push_back(rec);
            for (int c = 0; c < n; c++)
            begin
                rec = '0;
                rec.class_index = 3'(c);
                rec.truth_count = truth_cnt[c][19:0];
                rec.predicted_count = pred_cnt[c][19:0];
                rec.correct_count = hit_cnt[c][19:0];
                rec.mean_probability = 16'(mean_prob(prob_sum[c], truth_cnt[c]));
                rec.last = (c == n - 1);
                expected_records.push_back(rec);
            end
            clear_accumulators();
            return n + 1;
        end
        total_cnt = sat_inc(total_cnt);
        if (it.pixel_intensity < threshold)
            return 0;
        passed_cnt = sat_inc(passed_cnt);
        truth = int'(label_map[4 * it.label_type +: 4]);
        if (truth >= n)
            truth = 0;
        sc[0] = it.class_score_0;
        sc[1] = it.class_score_1;
        sc[2] = it.class_score_2;
        sc[3] = it.class_score_3;
        sc[4] = it.class_score_4;
        sc[5] = it.class_score_5;
        sc[6] = it.class_score_6;
        sc[7] = it.class_score_7;
        pred = 0;
        for (int c = 1; c < n; c++)
            if (sc[c] > sc[pred])
                pred = c;
        wsum = 0;
        wtruth = 0;
        for (int c = 0; c < n; c++)
        begin
            w = exp_weight(sc[pred] - sc[c]);
            wsum += w;
            if (c == truth)
                wtruth = w;
        end
        p = (wtruth << 16) / wsum;
        truth_cnt[truth] = sat_inc(truth_cnt[truth]);
        pred_cnt[pred] = sat_inc(pred_cnt[pred]);
        if (pred == truth)
        begin
            correct_cnt = sat_inc(correct_cnt);
            hit_cnt[truth] = sat_inc(hit_cnt[truth]);
        end
        prob_total = (prob_total + p > SUM_SAT) ? SUM_SAT : prob_total + p;
        prob_sum[truth] = (prob_sum[truth] + p > SUM_SAT) ? SUM_SAT : prob_sum[truth] + p;
        return 0;
    endfunction

    task automatic send_pixel(in_item_t it, bit typed, out_item_t first_rec);
        int gap;
        int nrec;
        gap = no_idle ? 0 : $urandom_range(0, 17);
        if (gap > 0)
        begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.data <= it;
        forever
        begin
            @(negedge clk);
            if (in_ch.ready)
                break;
        end
        @(posedge clk);
        nrec = accumulate_pixel(it);
        if (typed && nrec > 0)
            expected_records[expected_records.size() - nrec] = first_rec;
    endtask

    task automatic write_reg(cfg_reg_t idx, logic [63:0] value);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge clk);
        case (idx)
            CFG_THRESHOLD:   threshold = value[15:0];
            CFG_CLASS_COUNT: class_cfg = value[3:0];
            default:         label_map = value;
        endcase
    endtask

    task automatic drain();
        in_ch.valid <= 1'b0;
        wait (expected_records.size() == 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic configure(logic [15:0] thr, logic [3:0] cc, logic [63:0] map);
        drain();
        write_reg(CFG_THRESHOLD, {48'd0, thr});
        write_reg(CFG_CLASS_COUNT, {60'd0, cc});
        write_reg(CFG_LABEL_MAP, map);
        cfg_we <= 1'b0;
    endtask

    function automatic in_item_t random_pixel();
        in_item_t    it;
        logic [15:0] base;
        int          mode;
        it.command = ($urandom_range(0, 14) == 0) ? CMD_FINISH : CMD_PIXEL;
        it.pixel_intensity = ($urandom_range(0, 3) == 0) ? threshold : 16'($urandom);
        it.label_type = 4'($urandom);
        mode = $urandom_range(0, 2);
        base = 16'($urandom_range(0, 32767)) - 16'd16384;
        it.class_score_0 = 16'($urandom);
        it.class_score_1 = 16'($urandom);
        it.class_score_2 = 16'($urandom);
        it.class_score_3 = 16'($urandom);
        it.class_score_4 = 16'($urandom);
        it.class_score_5 = 16'($urandom);
        it.class_score_6 = 16'($urandom);
        it.class_score_7 = 16'($urandom);
        if (mode == 1)
        begin
            it.class_score_0 = base + 16'($urandom_range(0, 2047));
            it.class_score_1 = base + 16'($urandom_range(0, 2047));
            it.class_score_2 = base + 16'($urandom_range(0, 2047));
            it.class_score_3 = base + 16'($urandom_range(0, 2047));
            it.class_score_4 = base + 16'($urandom_range(0, 2047));
            it.class_score_5 = base + 16'($urandom_range(0, 2047));
            it.class_score_6 = base + 16'($urandom_range(0, 2047));
            it.class_score_7 = base + 16'($urandom_range(0, 2047));
        end
        else if (mode == 2)
        begin
            it.class_score_0 = base;
            it.class_score_1 = base + 16'($urandom_range(0, 1) * 256);
            it.class_score_2 = base;
            it.class_score_3 = base + 16'($urandom_range(0, 1) * 256);
            it.class_score_4 = base + 16'($urandom_range(0, 1) * 256);
            it.class_score_5 = base;
            it.class_score_6 = base + 16'($urandom_range(0, 1) * 256);
            it.class_score_7 = base;
        end
        return it;
    endfunction

    task automatic run_random(int count);
        in_item_t  it;
        in_item_t  fin;
        out_item_t none;
        none = '0;
        no_idle = ($urandom_range(0, 2) == 0);
        for (int i = 0; i < count; i++)
        begin
            it = random_pixel();
            send_pixel(it, 1'b0, none);
        end
        fin = random_pixel();
        fin.command = CMD_FINISH;
        send_pixel(fin, 1'b0, none);
    endtask

    task automatic run_directed();
        stim_row_t rows[$];
        stim_row_t row;
        in_item_t  px;
        px = '0;
        px.command = CMD_PIXEL;
        row.typed = 1'b0;
        row.first_record = '0;

        row.item = '0;
        row.item.command = CMD_FINISH;
        row.typed = 1'b1;
        row.first_record = '0;
        row.first_record.is_overall = 1'b1;
        rows.push_back(row);
        row.typed = 1'b0;

        row.item = px;
        row.item.pixel_intensity = -16'sd32768;
        rows.push_back(row);
        row.item = px;
        row.item.pixel_intensity = 16'sd32767;
        row.item.label_type = 4'd15;
        rows.push_back(row);
        row.item = px;
        row.item.class_score_0 = -16'sd32768;
        row.item.class_score_7 = 16'sd32767;
        rows.push_back(row);
        row.item = px;
        row.item.class_score_0 = 16'sd32767;
        row.item.class_score_1 = -16'sd32768;
        row.item.class_score_2 = -16'sd32768;
        row.item.class_score_3 = -16'sd32768;
        row.item.class_score_4 = -16'sd32768;
        row.item.class_score_5 = -16'sd32768;
        row.item.class_score_6 = -16'sd32768;
        row.item.class_score_7 = -16'sd32768;
        rows.push_back(row);
        row.item = px;
        row.item.class_score_0 = 16'sd32767;
        row.item.class_score_1 = 16'sd32767;
        row.item.class_score_2 = 16'sd32767;
        row.item.class_score_3 = 16'sd32767;
        row.item.class_score_4 = 16'sd32767;
        row.item.class_score_5 = 16'sd32767;
        row.item.class_score_6 = 16'sd32767;
        row.item.class_score_7 = 16'sd32767;
        rows.push_back(row);
        row.item = px;
        row.item.class_score_0 = 16'sd0;
        row.item.class_score_1 = 16'sd256;
        row.item.class_score_2 = 16'sd512;
        row.item.class_score_3 = 16'sd768;
        row.item.class_score_4 = 16'sd1024;
        row.item.class_score_5 = 16'sd1280;
        row.item.class_score_6 = 16'sd1536;
        row.item.class_score_7 = 16'sd1537;
        row.item.label_type = 4'd7;
        rows.push_back(row);
        row.item = px;
        row.item.pixel_intensity = -16'sd1;
        rows.push_back(row);
        row.item = '1;
        row.item.command = CMD_FINISH;
        rows.push_back(row);

        no_idle = 1'b0;
        foreach (rows[i])
            send_pixel(rows[i].item, rows[i].typed, rows[i].first_record);
    endtask

    task automatic check_field(string name, longint expv, longint actv);
        if (expv != actv)
        begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, expv, actv);
            errors++;
        end
    endtask

    initial
    begin
        out_item_t got;
        out_item_t want;
        int        gap;
        out_ch.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            gap = no_idle ? 0 : $urandom_range(0, 17);
            if (gap > 0)
            begin
                out_ch.ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            out_ch.ready <= 1'b1;
            forever
            begin
                @(negedge clk);
                if (out_ch.valid)
                    break;
            end
            got = out_ch.data;
            @(posedge clk);
            if (expected_records.size() == 0)
            begin
                $display("%0t: unexpected record, expected none, actual %p", $time, got);
                errors++;
            end
            else
            begin
                want = expected_records.pop_front();
                check_field("is_overall", want.is_overall, got.is_overall);
                check_field("class_index", want.class_index, got.class_index);
                check_field("total_pixels", want.total_pixels, got.total_pixels);
                check_field("passed_pixels", want.passed_pixels, got.passed_pixels);
                check_field("truth_count", want.truth_count, got.truth_count);
                check_field("predicted_count", want.predicted_count, got.predicted_count);
                check_field("correct_count", want.correct_count, got.correct_count);
                check_field("mean_probability", want.mean_probability,
                            got.mean_probability);
                check_field("last", want.last, got.last);
            end
        end
    end

    always @(posedge clk)
    begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("** segmentation_softmax_accuracy_stats: FAILED **");
            $finish;
        end
    end

    initial
    begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = CFG_THRESHOLD;
        cfg_data = '0;
        in_ch.valid = 1'b0;
        in_ch.data = '0;
        errors = 0;
        no_idle = 1'b0;
        threshold = '0;
        class_cfg = CCOUNT_RESET;
        label_map = '0;
        clear_accumulators();
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        run_directed();
        run_random(30);
        configure(16'h8000, 4'd0, {$urandom, $urandom});
        run_random(40);
        configure(16'h7FFF, 4'd15, {$urandom, $urandom});
        run_random(30);
        configure(16'($urandom_range(0, 511)) - 16'd256, 4'd2, 64'hFFFF_FFFF_FFFF_FFFF);
        run_random(40);
        configure(16'h0000, 4'd8, {$urandom, $urandom} & 64'h7777_7777_7777_7777);
        run_random(50);
        configure(16'($urandom), 4'($urandom), {$urandom, $urandom});
        run_random(40);
        drain();

        if (errors == 0)
            $display("** segmentation_softmax_accuracy_stats: PASSED **");
        else
            $display("** segmentation_softmax_accuracy_stats: FAILED **");
        $finish;
    end
endmodule

// ===== filelist.f =====
+incdir+hw/rtl
hw/rtl/ssas_pkg.sv
hw/rtl/ssas_in_if.sv
hw/rtl/ssas_out_if.sv
hw/rtl/ssas_controller.sv
hw/rtl/ssas_datapath.sv
hw/rtl/segmentation_softmax_accuracy_stats.sv
verif/tb.sv
